@@ src/rieu_pkg.sv @@
// shared types and codes for the integer execute unit
`timescale 1ns / 1ps
package rieu_pkg;

	localparam int NUM_REGS = 32;
	localparam int RIDX_W = $clog2(NUM_REGS);
	localparam logic [RIDX_W-1:0] LINK_REG = RIDX_W'(NUM_REGS - 1);

	localparam logic [5:0] OP_NOP = 6'd0, OP_ADD = 6'd1, OP_SUB = 6'd2, OP_ADDI = 6'd3,
		OP_SLT = 6'd4, OP_SLTU = 6'd5, OP_SLTI = 6'd6, OP_SLTIU = 6'd7, OP_AND = 6'd8,
		OP_OR = 6'd9, OP_XOR = 6'd10, OP_NOR = 6'd11, OP_ANDI = 6'd12, OP_ORI = 6'd13,
		OP_XORI = 6'd14, OP_SLL = 6'd15, OP_SRL = 6'd16, OP_SRA = 6'd17, OP_SLLV = 6'd18,
		OP_SRLV = 6'd19, OP_SRAV = 6'd20, OP_LUI = 6'd21, OP_MULT = 6'd22,
		OP_MULTU = 6'd23, OP_DIV = 6'd24, OP_DIVU = 6'd25, OP_MFHI = 6'd26,
		OP_MFLO = 6'd27, OP_MTHI = 6'd28, OP_MTLO = 6'd29, OP_BEQ = 6'd30,
		OP_BNE = 6'd31, OP_BLTZ = 6'd32, OP_BGEZ = 6'd33, OP_BGTZ = 6'd34,
		OP_BLEZ = 6'd35, OP_BLTZAL = 6'd36, OP_BGEZAL = 6'd37, OP_JAL = 6'd38,
		OP_JALR = 6'd39, OP_JR = 6'd40, OP_J = 6'd41, OP_RDHWR = 6'd42;

	localparam logic [1:0] ST_OK = 2'd0, ST_ILLEGAL = 2'd1, ST_DIV0 = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_MUL, S_DIV, S_DIVFIX, S_FIN
	} state_t;

	typedef struct packed {
		logic reg_written;
		logic [RIDX_W-1:0] written_index;
		logic [31:0] written_value;
		logic branch_taken;
		logic [31:0] next_addr;
		logic [1:0] status;
	} result_t;

endpackage

@@ src/risc_integer_execute_unit.sv @@
// integer execute unit: register file memory, hi/lo, multiply and iterative divide
// usage:
//  input channel in_valid/in_ready carries one decoded instruction word per item
//  output channel out_valid/out_ready carries one result word per instruction
//  cfg_we/cfg_wdata write the thread pointer register, taken at once
//  one instruction at a time: in_ready is high only while the unit is idle
//  steps for most operations: synchronous register file read at accept,
//  execute, commit; multiply adds a product step, divide adds 32 iterations
//  (one quotient bit a cycle) and a sign fix
//  a new instruction is accepted only after the previous one has committed
//  a result waits in the output register while out_ready is low; the next
//  finished result holds in the commit step until that register is free
//  reset clears the register file valid bits, hi, lo, thread pointer and control
`timescale 1ns / 1ps
module risc_integer_execute_unit
	import rieu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [5:0] mode,
	input  logic [4:0] src_a_index,
	input  logic [4:0] src_b_index,
	input  logic [4:0] dest_index,
	input  logic [15:0] immediate,
	input  logic [31:0] jump_target,
	input  logic [31:0] instr_addr,
	output logic out_valid,
	input  logic out_ready,
	output logic reg_written,
	output logic [4:0] written_index,
	output logic [31:0] written_value,
	output logic branch_taken,
	output logic [31:0] next_addr,
	output logic [1:0] status,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata
);

	state_t state_q, state_d;

	logic [31:0] rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [31:0] rda_q, rdb_q;
	logic [5:0] mode_q;
	logic [4:0] rs_q, rt_q, rd_q;
	logic [15:0] imm_q;
	logic [31:0] tgt_q, addr_q;
	logic [31:0] hi_q, lo_q, tp_q;
	logic [31:0] hi_w_q, lo_w_q;
	logic hi_we_q, lo_we_q;
	result_t res_q, res_d, out_q;
	logic out_valid_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [4:0] cnt_q;
	logic na_q, nq_q, sgn_q;

	logic in_acc, fin_go;
	logic [31:0] a, b, sx_imm, zx_imm, link;
	logic [65:0] prod;
	logic [32:0] rem_sh, diff;

	assign in_acc = in_valid && in_ready;
	assign a = (rs_q != '0 && vld_q[rs_q]) ? rda_q : '0;
	assign b = (rt_q != '0 && vld_q[rt_q]) ? rdb_q : '0;
	assign sx_imm = {{16{imm_q[15]}}, imm_q};
	assign zx_imm = {16'h0000, imm_q};
	assign link = addr_q + 32'd8;
	assign prod = $signed({sgn_q & a[31], a}) * $signed({sgn_q & b[31], b});
	assign rem_sh = {rem_q, quo_q[31]};
	assign diff = rem_sh - {1'b0, dvs_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_acc) state_d = S_EXEC;
			S_EXEC: begin
				if (mode_q == OP_MULT || mode_q == OP_MULTU) state_d = S_MUL;
				else if ((mode_q == OP_DIV || mode_q == OP_DIVU) && b != '0) state_d = S_DIV;
				else state_d = S_FIN;
			end
			S_MUL: state_d = S_FIN;
			S_DIV: if (cnt_q == 5'd31) state_d = S_DIVFIX;
			S_DIVFIX: state_d = S_FIN;
			S_FIN: if (fin_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = (state_q == S_IDLE);
		fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	// execute
	always_comb begin
		logic wr;
		logic [4:0] widx;
		logic [31:0] wval;
		logic taken, isbr;
		logic [31:0] tgt;
		wr = 1'b0;
		widx = '0;
		wval = '0;
		taken = 1'b0;
		isbr = 1'b0;
		tgt = tgt_q;
		res_d = '0;
		case (mode_q)
			OP_NOP: ;
			OP_ADD: begin wr = 1'b1; widx = rd_q; wval = a + b; end
			OP_SUB: begin wr = 1'b1; widx = rd_q; wval = a - b; end
			OP_ADDI: begin wr = 1'b1; widx = rt_q; wval = a + sx_imm; end
			OP_SLT: begin wr = 1'b1; widx = rd_q; wval = {31'd0, $signed(a) < $signed(b)}; end
			OP_SLTU: begin wr = 1'b1; widx = rd_q; wval = {31'd0, a < b}; end
			OP_SLTI: begin
				wr = 1'b1; widx = rt_q; wval = {31'd0, $signed(a) < $signed(sx_imm)};
			end
			OP_SLTIU: begin wr = 1'b1; widx = rt_q; wval = {31'd0, a < sx_imm}; end
			OP_AND: begin wr = 1'b1; widx = rd_q; wval = a & b; end
			OP_OR: begin wr = 1'b1; widx = rd_q; wval = a | b; end
			OP_XOR: begin wr = 1'b1; widx = rd_q; wval = a ^ b; end
			OP_NOR: begin wr = 1'b1; widx = rd_q; wval = ~(a | b); end
			OP_ANDI: begin wr = 1'b1; widx = rt_q; wval = a & zx_imm; end
			OP_ORI: begin wr = 1'b1; widx = rt_q; wval = a | zx_imm; end
			OP_XORI: begin wr = 1'b1; widx = rt_q; wval = a ^ zx_imm; end
			OP_SLL: begin wr = 1'b1; widx = rd_q; wval = b << imm_q[4:0]; end
			OP_SRL: begin wr = 1'b1; widx = rd_q; wval = b >> imm_q[4:0]; end
			OP_SRA: begin wr = 1'b1; widx = rd_q; wval = $signed(b) >>> imm_q[4:0]; end
			OP_SLLV: begin wr = 1'b1; widx = rd_q; wval = b << a[4:0]; end
			OP_SRLV: begin wr = 1'b1; widx = rd_q; wval = b >> a[4:0]; end
			OP_SRAV: begin wr = 1'b1; widx = rd_q; wval = $signed(b) >>> a[4:0]; end
			OP_LUI: begin wr = 1'b1; widx = rt_q; wval = {imm_q, 16'h0000}; end
			OP_MULT, OP_MULTU, OP_DIVU, OP_MTHI, OP_MTLO: ;
			OP_DIV: ;
			OP_MFHI: begin wr = 1'b1; widx = rd_q; wval = hi_q; end
			OP_MFLO: begin wr = 1'b1; widx = rd_q; wval = lo_q; end
			OP_BEQ: begin isbr = 1'b1; taken = (a == b); end
			OP_BNE: begin isbr = 1'b1; taken = (a != b); end
			OP_BLTZ: begin isbr = 1'b1; taken = a[31]; end
			OP_BGEZ: begin isbr = 1'b1; taken = !a[31]; end
			OP_BGTZ: begin isbr = 1'b1; taken = (a != '0) && !a[31]; end
			OP_BLEZ: begin isbr = 1'b1; taken = (a == '0) || a[31]; end
			OP_BLTZAL: begin
				isbr = 1'b1; taken = a[31]; wr = 1'b1; widx = LINK_REG; wval = link;
			end
			OP_BGEZAL: begin
				isbr = 1'b1; taken = !a[31]; wr = 1'b1; widx = LINK_REG; wval = link;
			end
			OP_JAL: begin taken = 1'b1; wr = 1'b1; widx = LINK_REG; wval = link; end
			OP_JALR: begin taken = 1'b1; tgt = a; wr = 1'b1; widx = rd_q; wval = link; end
			OP_JR: begin taken = 1'b1; tgt = a; end
			OP_J: taken = 1'b1;
			OP_RDHWR: begin wr = 1'b1; widx = rt_q; wval = tp_q; end
			default: res_d.status = ST_ILLEGAL;
		endcase
		if ((mode_q == OP_DIV || mode_q == OP_DIVU) && b == '0) res_d.status = ST_DIV0;
		if (wr && widx != '0) begin
			res_d.reg_written = 1'b1;
			res_d.written_index = widx;
			res_d.written_value = wval;
		end
		res_d.branch_taken = taken;
		res_d.next_addr = taken ? tgt : addr_q + (isbr ? 32'd8 : 32'd4);
	end

	// register file memory
	always_ff @(posedge clk) begin
		if (fin_go && res_q.reg_written) rf_mem[res_q.written_index] <= res_q.written_value;
		if (in_acc) begin
			rda_q <= rf_mem[src_a_index];
			rdb_q <= rf_mem[src_b_index];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			rs_q <= src_a_index;
			rt_q <= src_b_index;
			rd_q <= dest_index;
			imm_q <= immediate;
			tgt_q <= jump_target;
			addr_q <= instr_addr;
			sgn_q <= (mode == OP_MULT) || (mode == OP_DIV);
		end
		if (state_q == S_EXEC) begin
			res_q <= res_d;
			hi_w_q <= a;
			lo_w_q <= a;
			na_q <= sgn_q & a[31];
			nq_q <= sgn_q & (a[31] ^ b[31]);
			quo_q <= (sgn_q & a[31]) ? -a : a;
			dvs_q <= (sgn_q & b[31]) ? -b : b;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == S_MUL) begin
			hi_w_q <= prod[63:32];
			lo_w_q <= prod[31:0];
		end
		if (state_q == S_DIV) begin
			cnt_q <= cnt_q + 5'd1;
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (state_q == S_DIVFIX) begin
			lo_w_q <= nq_q ? -quo_q : quo_q;
			hi_w_q <= na_q ? -rem_q : rem_q;
		end
		if (fin_go) out_q <= res_q;
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			tp_q <= '0;
			hi_we_q <= 1'b0;
			lo_we_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) tp_q <= cfg_wdata;
			if (state_q == S_EXEC) begin
				hi_we_q <= (mode_q == OP_MTHI);
				lo_we_q <= (mode_q == OP_MTLO);
			end
			if (state_q == S_MUL || state_q == S_DIVFIX) begin
				hi_we_q <= 1'b1;
				lo_we_q <= 1'b1;
			end
			if (fin_go) begin
				if (res_q.reg_written) vld_q[res_q.written_index] <= 1'b1;
				if (hi_we_q) hi_q <= hi_w_q;
				if (lo_we_q) lo_q <= lo_w_q;
			end
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign reg_written = out_q.reg_written;
	assign written_index = out_q.written_index;
	assign written_value = out_q.written_value;
	assign branch_taken = out_q.branch_taken;
	assign next_addr = out_q.next_addr;
	assign status = out_q.status;

endmodule

@@ bench/tb_risc_integer_execute_unit.sv @@
// testbench for the integer execute unit: directed and random instruction words against a predictor
`timescale 1ns / 1ps
module tb_risc_integer_execute_unit;
	import rieu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [5:0] mode = '0;
	logic [4:0] src_a_index = '0, src_b_index = '0, dest_index = '0;
	logic [15:0] immediate = '0;
	logic [31:0] jump_target = '0, instr_addr = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic reg_written;
	logic [4:0] written_index;
	logic [31:0] written_value;
	logic branch_taken;
	logic [31:0] next_addr;
	logic [1:0] status;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	risc_integer_execute_unit i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .src_a_index(src_a_index), .src_b_index(src_b_index),
		.dest_index(dest_index), .immediate(immediate), .jump_target(jump_target),
		.instr_addr(instr_addr), .out_valid(out_valid), .out_ready(out_ready),
		.reg_written(reg_written), .written_index(written_index),
		.written_value(written_value), .branch_taken(branch_taken),
		.next_addr(next_addr), .status(status), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	logic [31:0] gpr [32];
	logic [31:0] hi_q, lo_q, tp_q;
	result_t pending_results[$];
	int n_errors = 0, n_words = 0, n_results = 0;
	int send_idle_pct = 0, recv_stall_pct = 0, hold_off = 0;
	longint cycle_count = 0;

	function automatic result_t execute_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [15:0] imm, logic [31:0] tgt, logic [31:0] pc);
		result_t r;
		logic [31:0] a, b, simm, ua, ub, q, rm;
		logic [63:0] p;
		logic wr, taken, isbr;
		logic [4:0] widx;
		logic [31:0] wval;
		a = (rs == 0) ? 32'd0 : gpr[rs];
		b = (rt == 0) ? 32'd0 : gpr[rt];
		simm = {{16{imm[15]}}, imm};
		wr = 1'b0; taken = 1'b0; isbr = 1'b0; widx = '0; wval = '0;
		r.status = ST_OK;
		case (op)
			OP_NOP: ;
			OP_ADD: begin wr = 1; widx = rd; wval = a + b; end
			OP_SUB: begin wr = 1; widx = rd; wval = a - b; end
			OP_ADDI: begin wr = 1; widx = rt; wval = a + simm; end
			OP_SLT: begin wr = 1; widx = rd; wval = {31'd0, $signed(a) < $signed(b)}; end
			OP_SLTU: begin wr = 1; widx = rd; wval = {31'd0, a < b}; end
			OP_SLTI: begin wr = 1; widx = rt; wval = {31'd0, $signed(a) < $signed(simm)}; end
			OP_SLTIU: begin wr = 1; widx = rt; wval = {31'd0, a < simm}; end
			OP_AND: begin wr = 1; widx = rd; wval = a & b; end
			OP_OR: begin wr = 1; widx = rd; wval = a | b; end
			OP_XOR: begin wr = 1; widx = rd; wval = a ^ b; end
			OP_NOR: begin wr = 1; widx = rd; wval = ~(a | b); end
			OP_ANDI: begin wr = 1; widx = rt; wval = a & {16'd0, imm}; end
			OP_ORI: begin wr = 1; widx = rt; wval = a | {16'd0, imm}; end
			OP_XORI: begin wr = 1; widx = rt; wval = a ^ {16'd0, imm}; end
			OP_SLL: begin wr = 1; widx = rd; wval = b << imm[4:0]; end
			OP_SRL: begin wr = 1; widx = rd; wval = b >> imm[4:0]; end
			OP_SRA: begin wr = 1; widx = rd; wval = $signed(b) >>> imm[4:0]; end
			OP_SLLV: begin wr = 1; widx = rd; wval = b << a[4:0]; end
			OP_SRLV: begin wr = 1; widx = rd; wval = b >> a[4:0]; end
			OP_SRAV: begin wr = 1; widx = rd; wval = $signed(b) >>> a[4:0]; end
			OP_LUI: begin wr = 1; widx = rt; wval = {imm, 16'd0}; end
			OP_MULT: begin
				p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
				{hi_q, lo_q} = p;
			end
			OP_MULTU: begin
				p = {32'd0, a} * {32'd0, b};
				{hi_q, lo_q} = p;
			end
			OP_DIV: begin
				if (b == 0) r.status = ST_DIV0;
				else begin
					ua = a[31] ? -a : a;
					ub = b[31] ? -b : b;
					q = ua / ub;
					rm = ua % ub;
					lo_q = (a[31] != b[31]) ? -q : q;
					hi_q = a[31] ? -rm : rm;
				end
			end
			OP_DIVU: begin
				if (b == 0) r.status = ST_DIV0;
				else begin
					lo_q = a / b;
					hi_q = a % b;
				end
			end
			OP_MFHI: begin wr = 1; widx = rd; wval = hi_q; end
			OP_MFLO: begin wr = 1; widx = rd; wval = lo_q; end
			OP_MTHI: hi_q = a;
			OP_MTLO: lo_q = a;
			OP_BEQ: begin isbr = 1; taken = (a == b); end
			OP_BNE: begin isbr = 1; taken = (a != b); end
			OP_BLTZ: begin isbr = 1; taken = a[31]; end
			OP_BGEZ: begin isbr = 1; taken = !a[31]; end
			OP_BGTZ: begin isbr = 1; taken = (a != 0) && !a[31]; end
			OP_BLEZ: begin isbr = 1; taken = (a == 0) || a[31]; end
			OP_BLTZAL: begin isbr = 1; taken = a[31]; wr = 1; widx = LINK_REG; wval = pc + 8; end
			OP_BGEZAL: begin isbr = 1; taken = !a[31]; wr = 1; widx = LINK_REG; wval = pc + 8; end
			OP_JAL: begin taken = 1; wr = 1; widx = LINK_REG; wval = pc + 8; end
			OP_JALR: begin taken = 1; tgt = a; wr = 1; widx = rd; wval = pc + 8; end
			OP_JR: begin taken = 1; tgt = a; end
			OP_J: taken = 1;
			OP_RDHWR: begin wr = 1; widx = rt; wval = tp_q; end
			default: r.status = ST_ILLEGAL;
		endcase
		if (wr && widx != 0) gpr[widx] = wval;
		else begin
			wr = 0; widx = 0; wval = 0;
		end
		r.reg_written = wr;
		r.written_index = widx;
		r.written_value = wval;
		r.branch_taken = taken;
		r.next_addr = taken ? tgt : pc + (isbr ? 32'd8 : 32'd4);
		return r;
	endfunction

	task automatic send_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [15:0] imm, logic [31:0] tgt, logic [31:0] pc);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode <= op; src_a_index <= rs; src_b_index <= rt; dest_index <= rd;
		immediate <= imm; jump_target <= tgt; instr_addr <= pc;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(execute_word(op, rs, rt, rd, imm, tgt, pc));
		n_words++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'hffff_ffff;
			2: return $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(int count);
		logic [5:0] op;
		repeat (count) begin
			op = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(42));
			if ($urandom_range(4) == 0)
				send_word(OP_LUI, 0, 5'($urandom), 0, 16'($urandom), 0, 0);
			else if ($urandom_range(6) == 0)
				send_word(OP_ORI, 5'($urandom), 5'($urandom), 0, 16'(rand_value()), 0, 0);
			else
				send_word(op, 5'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
					$urandom, $urandom);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_thread_pointer(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tp_q = v;
	endtask

	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		result_t exp_r;
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("timeout at %0t", $time);
			$display("TEST FAILED");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				n_errors++;
				$display("%0t unexpected result word", $time);
			end else begin
				exp_r = pending_results.pop_front();
				if ({reg_written, written_index, written_value, branch_taken, next_addr, status}
						!== exp_r) begin
					n_errors++;
					$display("%0t mismatch exp wr=%0d idx=%0d val=%h br=%0d nxt=%h st=%0d",
						$time, exp_r.reg_written, exp_r.written_index, exp_r.written_value,
						exp_r.branch_taken, exp_r.next_addr, exp_r.status);
					$display("%0t          got wr=%0d idx=%0d val=%h br=%0d nxt=%h st=%0d",
						$time, reg_written, written_index, written_value, branch_taken,
						next_addr, status);
				end
			end
		end
	end

	task automatic test_directed();
		send_word(OP_LUI, 0, 1, 0, 16'h8000, 0, 0);
		send_word(OP_ADDI, 0, 2, 0, 16'hffff, 0, 0);
		send_word(OP_ADD, 1, 2, 3, 0, 0, 32'hffff_fffc);
		send_word(OP_SUB, 1, 2, 0, 0, 0, 0);
		send_word(OP_DIV, 1, 2, 0, 0, 0, 0);
		send_word(OP_MFLO, 0, 0, 4, 0, 0, 0);
		send_word(OP_MFHI, 0, 0, 5, 0, 0, 0);
		send_word(OP_DIVU, 1, 0, 0, 0, 0, 0);
		send_word(OP_MFLO, 0, 0, 6, 0, 0, 0);
		send_word(OP_MULT, 1, 1, 0, 0, 0, 0);
		send_word(OP_MFHI, 0, 0, 7, 0, 0, 0);
		send_word(OP_MULTU, 2, 2, 0, 0, 0, 0);
		send_word(OP_MFHI, 0, 0, 8, 0, 0, 0);
		send_word(OP_SRA, 0, 1, 9, 16'h001f, 0, 0);
		send_word(OP_SRAV, 2, 1, 10, 0, 0, 0);
		send_word(OP_SLTIU, 1, 11, 0, 16'h8000, 0, 0);
		send_word(OP_BLTZAL, 1, 0, 0, 0, 32'h1234_5678, 32'hffff_fff8);
		send_word(OP_BGEZAL, 1, 0, 0, 0, 32'h1234_5678, 32'h0000_1000);
		send_word(OP_JALR, 31, 0, 31, 0, 0, 32'h0000_2000);
		send_word(OP_JR, 1, 0, 0, 0, 0, 0);
		send_word(OP_RDHWR, 0, 12, 0, 0, 0, 0);
		send_word(6'd63, 1, 2, 3, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
		send_word(OP_ADD, 1, 1, 0, 0, 0, 0);
		send_word(OP_NOP, 31, 31, 31, 16'hffff, 32'hffff_ffff, 32'h7fff_fffc);
		drain();
	endtask

	task automatic test_random_phases();
		int sp[4] = '{0, 75, 0, 30};
		int rp[4] = '{0, 0, 75, 30};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = sp[ph];
			recv_stall_pct = rp[ph];
			write_thread_pointer(ph == 0 ? 32'hffff_ffff : $urandom);
			send_random(110);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_off = 300;
		send_random(40);
		drain();
		write_thread_pointer(32'd0);
		send_random(20);
		drain();
	endtask

	initial begin
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		hi_q = '0; lo_q = '0; tp_q = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_phases();
		test_backpressure();
		$display("sent %0d instruction words, checked %0d results", n_words, n_results);
		$display("all ops, divide corners, links and thread pointer writes under stalls");
		if (n_errors == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
